### sv/rmlu_pkg.sv
// ----------------------------------------------------------------------------
// Reentrant monitor lock unit package
// Shared constants, request and status codes, controller state and the
// command and status structures between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rmlu_pkg;

    localparam int THREAD_COUNT_DEF = 16;
    localparam int DEPTH_MAX_DEF    = 255;

    localparam int TID_W    = 4;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 4;
    localparam int NEST_W   = 8;
    localparam int MOVED_W  = 5;

    localparam logic [REQ_W-1:0] REQ_LOCK       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TRY_LOCK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNLOCK     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WAIT       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TIMEOUT    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_NOTIFY     = 3'd5;
    localparam logic [REQ_W-1:0] REQ_NOTIFY_ALL = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED     = 3'd7;

    localparam logic [STATUS_W-1:0] ST_GRANTED     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_NESTED      = 4'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_DECREMENTED = 4'd4;
    localparam logic [STATUS_W-1:0] ST_RELEASED    = 4'd5;
    localparam logic [STATUS_W-1:0] ST_WAITING     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NOTIFIED    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_NONE_WAIT   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_NOT_HOLDER  = 4'd9;
    localparam logic [STATUS_W-1:0] ST_BLOCKED     = 4'd10;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 4'd11;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 4'd12;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NT_READ,
        S_NT_MOVE,
        S_GRANT,
        S_GR_SAVED,
        S_GR_TAKE,
        S_TO_READ,
        S_TO_CMP,
        S_SH_READ,
        S_SH_WRITE,
        S_TO_OWN,
        S_TO_TAKE,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOCK_GRANT,
        OP_NEST_INC,
        OP_LOCK_QUEUE,
        OP_NEST_DEC,
        OP_RELEASE,
        OP_WAIT_ENTER,
        OP_NT_READ,
        OP_NT_MOVE,
        OP_GR_READ,
        OP_GR_READ_SAVED,
        OP_GR_TAKE,
        OP_TO_READ,
        OP_TO_NEXT,
        OP_TO_FOUND,
        OP_SH_READ,
        OP_SH_WRITE,
        OP_TO_DROP,
        OP_TO_READ_SAVED,
        OP_TO_TAKE,
        OP_TO_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             tid_bad;
        logic             blocked;
        logic             holds;
        logic             owner_valid;
        logic             depth_at_max;
        logic             depth_gt1;
        logic             wait_empty;
        logic             wait_gt1;
        logic             ready_empty;
        logic             match;
        logic             idx_next_lt_fill;
    } stat_t;

endpackage

`default_nettype wire

### sv/rmlu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmlu_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### sv/rmlu_ctrl.sv
// ----------------------------------------------------------------------------
// Reentrant monitor lock unit controller
// Sequences each request through the datapath and runs the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rmlu_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire rmlu_pkg::stat_t st,
    output rmlu_pkg::cmd_t      cmd
);

    import rmlu_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    state_t              dec_state;
    dp_op_t              dec_op;
    logic [STATUS_W-1:0] dec_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        dec_state  = S_OUT;
        dec_op     = OP_NONE;
        dec_status = ST_REFUSED;
        priority if (st.tid_bad)
        begin
            dec_status = ST_BLOCKED;
        end
        else if (st.req == REQ_TIMEOUT)
        begin
            dec_status = ST_TIMEOUT;
            dec_state  = st.wait_empty ? S_OUT : S_TO_READ;
        end
        else if (st.req == REQ_UNUSED)
        begin
            dec_status = ST_REFUSED;
        end
        else if (st.blocked)
        begin
            dec_status = ST_BLOCKED;
        end
        else if (st.req == REQ_LOCK || st.req == REQ_TRY_LOCK)
        begin
            priority if (!st.owner_valid)
            begin
                dec_op     = OP_LOCK_GRANT;
                dec_status = ST_GRANTED;
            end
            else if (st.holds)
            begin
                if (st.depth_at_max)
                begin
                    dec_status = ST_OVERFLOW;
                end
                else
                begin
                    dec_op     = OP_NEST_INC;
                    dec_status = ST_NESTED;
                end
            end
            else if (st.req == REQ_LOCK)
            begin
                dec_op     = OP_LOCK_QUEUE;
                dec_status = ST_QUEUED;
            end
            else
            begin
                dec_status = ST_REFUSED;
            end
        end
        else if (st.req == REQ_UNLOCK)
        begin
            priority if (!st.holds)
            begin
                dec_status = ST_NOT_HOLDER;
            end
            else if (st.depth_gt1)
            begin
                dec_op     = OP_NEST_DEC;
                dec_status = ST_DECREMENTED;
            end
            else
            begin
                dec_op     = OP_RELEASE;
                dec_status = ST_RELEASED;
                dec_state  = S_GRANT;
            end
        end
        else if (st.req == REQ_WAIT)
        begin
            if (!st.holds)
            begin
                dec_status = ST_NOT_HOLDER;
            end
            else
            begin
                dec_op     = OP_WAIT_ENTER;
                dec_status = ST_WAITING;
                dec_state  = S_GRANT;
            end
        end
        else
        begin
            if (st.wait_empty)
            begin
                dec_status = ST_NONE_WAIT;
            end
            else
            begin
                dec_status = ST_NOTIFIED;
                dec_state  = S_NT_READ;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     state_next = in_valid ? S_DECODE : S_IDLE;
            S_DECODE:   state_next = dec_state;
            S_NT_READ:  state_next = S_NT_MOVE;
            S_NT_MOVE:  state_next = (st.req == REQ_NOTIFY_ALL && st.wait_gt1) ?
                                     S_NT_READ : S_GRANT;
            S_GRANT:    state_next = (!st.owner_valid && !st.ready_empty) ?
                                     S_GR_SAVED : S_OUT;
            S_GR_SAVED: state_next = S_GR_TAKE;
            S_GR_TAKE:  state_next = S_OUT;
            S_TO_READ:  state_next = S_TO_CMP;
            S_TO_CMP:
            begin
                priority if (st.match)
                begin
                    state_next = S_SH_READ;
                end
                else if (st.idx_next_lt_fill)
                begin
                    state_next = S_TO_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SH_READ:  state_next = st.idx_next_lt_fill ? S_SH_WRITE : S_TO_OWN;
            S_SH_WRITE: state_next = S_SH_READ;
            S_TO_OWN:   state_next = st.owner_valid ? S_OUT : S_TO_TAKE;
            S_TO_TAKE:  state_next = S_OUT;
            S_OUT:      state_next = out_stall ? S_OUT : S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op          = OP_NONE;
        cmd.set_status  = 1'b0;
        cmd.status_code = dec_status;
        in_stall        = (state_reg != S_IDLE);
        out_valid       = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE:     cmd.op = in_valid ? OP_CAPTURE : OP_NONE;
            S_DECODE:
            begin
                cmd.op         = dec_op;
                cmd.set_status = 1'b1;
            end
            S_NT_READ:  cmd.op = OP_NT_READ;
            S_NT_MOVE:  cmd.op = OP_NT_MOVE;
            S_GRANT:    cmd.op = (!st.owner_valid && !st.ready_empty) ?
                                 OP_GR_READ : OP_NONE;
            S_GR_SAVED: cmd.op = OP_GR_READ_SAVED;
            S_GR_TAKE:  cmd.op = OP_GR_TAKE;
            S_TO_READ:  cmd.op = OP_TO_READ;
            S_TO_CMP:
            begin
                priority if (st.match)
                begin
                    cmd.op = OP_TO_FOUND;
                end
                else if (st.idx_next_lt_fill)
                begin
                    cmd.op = OP_TO_NEXT;
                end
                else
                begin
                    cmd.op = OP_NONE;
                end
            end
            S_SH_READ:  cmd.op = st.idx_next_lt_fill ? OP_SH_READ : OP_TO_DROP;
            S_SH_WRITE: cmd.op = OP_SH_WRITE;
            S_TO_OWN:   cmd.op = st.owner_valid ? OP_TO_PUSH : OP_TO_READ_SAVED;
            S_TO_TAKE:  cmd.op = OP_TO_TAKE;
            S_OUT:      cmd.op = OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

### sv/rmlu_dp.sv
// ----------------------------------------------------------------------------
// Reentrant monitor lock unit datapath
// Holder registers, ready queue, wait list, saved depths and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module rmlu_dp #(
    parameter int THREAD_COUNT = rmlu_pkg::THREAD_COUNT_DEF,
    parameter int DEPTH_MAX    = rmlu_pkg::DEPTH_MAX_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rmlu_pkg::cmd_t                   cmd,
    output rmlu_pkg::stat_t                       st,
    input  wire logic [rmlu_pkg::REQ_W-1:0]       req_type,
    input  wire logic [rmlu_pkg::TID_W-1:0]       thread_id,
    output logic      [rmlu_pkg::STATUS_W-1:0]    status,
    output logic                                  timed_out,
    output logic                                  woken_valid,
    output logic      [rmlu_pkg::TID_W-1:0]       woken_thread,
    output logic                                  holder_valid,
    output logic      [rmlu_pkg::TID_W-1:0]       holder_now,
    output logic      [rmlu_pkg::NEST_W-1:0]      nest_count,
    output logic      [rmlu_pkg::MOVED_W-1:0]     moved_count
);

    import rmlu_pkg::*;

    localparam int TW = $clog2(THREAD_COUNT);
    localparam int DW = $clog2(DEPTH_MAX + 1);

    logic [REQ_W-1:0]    req_reg;
    logic [TID_W-1:0]    tid_reg;
    logic                owner_valid_reg;
    logic [TID_W-1:0]    owner_id_reg;
    logic [DW-1:0]       owner_depth_reg;
    logic [TW-1:0]       ready_head_reg;
    logic [TW:0]         ready_fill_reg;
    logic [TW-1:0]       wait_head_reg;
    logic [TW:0]         wait_fill_reg;
    logic [TW-1:0]       idx_reg;
    logic [TID_W-1:0]    grant_tid_reg;
    logic [TW:0]         moved_reg;
    logic [THREAD_COUNT-1:0] blocked_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                timed_reg;
    logic                woke_reg;
    logic [TID_W-1:0]    woken_reg;

    logic                fifo_we;
    logic [TW-1:0]       fifo_waddr;
    logic [TW-1:0]       fifo_raddr;
    logic [TID_W-1:0]    fifo_wdata;
    logic [TID_W-1:0]    fifo_rdata;
    logic                wait_we;
    logic [TW-1:0]       wait_waddr;
    logic [TW-1:0]       wait_raddr;
    logic [TID_W-1:0]    wait_wdata;
    logic [TID_W-1:0]    wait_rdata;
    logic                saved_we;
    logic [TW-1:0]       saved_waddr;
    logic [TW-1:0]       saved_raddr;
    logic [DW-1:0]       saved_wdata;
    logic [DW-1:0]       saved_rdata;

    logic                push_en;
    logic                push_ok;
    logic [TID_W-1:0]    push_data;
    logic                wait_ok;

    logic [TW+TID_W-1:0] tid_ext;
    logic [TW+TID_W-1:0] push_ext;
    logic [TW+TID_W-1:0] grant_ext;
    logic [TW+TID_W-1:0] fifo_ext;
    logic [TW-1:0]       tid_idx;
    logic [TW-1:0]       push_idx;
    logic [TW-1:0]       grant_idx;
    logic [TW-1:0]       fifo_idx;
    logic [TW:0]         idx_plus1;
    logic [DW+NEST_W-1:0]  depth_ext;
    logic [TW+MOVED_W:0]   moved_ext;

    function automatic logic [TW-1:0] wrap_add(input logic [TW-1:0] base,
                                               input logic [TW:0] off);
        logic [TW+1:0] s;
        s = {2'b00, base} + {1'b0, off};
        if (s >= (TW+2)'(THREAD_COUNT))
        begin
            s = s - (TW+2)'(THREAD_COUNT);
        end
        return s[TW-1:0];
    endfunction

    assign tid_ext   = {{TW{1'b0}}, tid_reg};
    assign push_ext  = {{TW{1'b0}}, push_data};
    assign grant_ext = {{TW{1'b0}}, grant_tid_reg};
    assign fifo_ext  = {{TW{1'b0}}, fifo_rdata};
    assign tid_idx   = tid_ext[TW-1:0];
    assign push_idx  = push_ext[TW-1:0];
    assign grant_idx = grant_ext[TW-1:0];
    assign fifo_idx  = fifo_ext[TW-1:0];
    assign idx_plus1 = {1'b0, idx_reg} + (TW+1)'(1);

    assign push_en   = (cmd.op == OP_LOCK_QUEUE) || (cmd.op == OP_NT_MOVE) ||
                       (cmd.op == OP_TO_PUSH);
    assign push_data = (cmd.op == OP_NT_MOVE) ? wait_rdata : tid_reg;
    assign push_ok   = push_en && (ready_fill_reg < (TW+1)'(THREAD_COUNT));
    assign wait_ok   = (cmd.op == OP_WAIT_ENTER) &&
                       (wait_fill_reg < (TW+1)'(THREAD_COUNT));

    assign fifo_we    = push_ok;
    assign fifo_waddr = wrap_add(ready_head_reg, ready_fill_reg);
    assign fifo_wdata = push_data;
    assign fifo_raddr = ready_head_reg;

    always_comb
    begin
        wait_we     = wait_ok;
        wait_waddr  = wrap_add(wait_head_reg, wait_fill_reg);
        wait_wdata  = tid_reg;
        if (cmd.op == OP_SH_WRITE)
        begin
            wait_we    = 1'b1;
            wait_waddr = wrap_add(wait_head_reg, {1'b0, idx_reg});
            wait_wdata = wait_rdata;
        end
        unique case (cmd.op)
            OP_TO_READ: wait_raddr = wrap_add(wait_head_reg, {1'b0, idx_reg});
            OP_SH_READ: wait_raddr = wrap_add(wait_head_reg, idx_plus1);
            default:    wait_raddr = wait_head_reg;
        endcase
    end

    always_comb
    begin
        saved_we    = wait_ok || (cmd.op == OP_LOCK_QUEUE);
        saved_waddr = tid_idx;
        saved_wdata = (cmd.op == OP_LOCK_QUEUE) ? DW'(1) : owner_depth_reg;
        saved_raddr = (cmd.op == OP_GR_READ_SAVED) ? fifo_idx : tid_idx;
    end

    rmlu_ram #(.WIDTH(TID_W), .DEPTH(THREAD_COUNT)) u_ready_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    rmlu_ram #(.WIDTH(TID_W), .DEPTH(THREAD_COUNT)) u_wait_ram (
        .clk   (clk),
        .we    (wait_we),
        .waddr (wait_waddr),
        .wdata (wait_wdata),
        .raddr (wait_raddr),
        .rdata (wait_rdata)
    );

    rmlu_ram #(.WIDTH(DW), .DEPTH(THREAD_COUNT)) u_saved_ram (
        .clk   (clk),
        .we    (saved_we),
        .waddr (saved_waddr),
        .wdata (saved_wdata),
        .raddr (saved_raddr),
        .rdata (saved_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_valid_reg <= 1'b0;
            owner_id_reg    <= '0;
            owner_depth_reg <= '0;
            ready_head_reg  <= '0;
            ready_fill_reg  <= '0;
            wait_head_reg   <= '0;
            wait_fill_reg   <= '0;
            idx_reg         <= '0;
            blocked_reg     <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                ready_fill_reg        <= ready_fill_reg + (TW+1)'(1);
                blocked_reg[push_idx] <= 1'b1;
            end
            unique case (cmd.op)
                OP_CAPTURE:
                begin
                    idx_reg <= '0;
                end
                OP_LOCK_GRANT:
                begin
                    owner_valid_reg <= 1'b1;
                    owner_id_reg    <= tid_reg;
                    owner_depth_reg <= DW'(1);
                end
                OP_NEST_INC: owner_depth_reg <= owner_depth_reg + DW'(1);
                OP_NEST_DEC: owner_depth_reg <= owner_depth_reg - DW'(1);
                OP_RELEASE, OP_WAIT_ENTER:
                begin
                    owner_valid_reg <= 1'b0;
                    owner_id_reg    <= '0;
                    owner_depth_reg <= '0;
                    if (wait_ok)
                    begin
                        wait_fill_reg        <= wait_fill_reg + (TW+1)'(1);
                        blocked_reg[tid_idx] <= 1'b1;
                    end
                end
                OP_NT_MOVE:
                begin
                    wait_head_reg <= wrap_add(wait_head_reg, (TW+1)'(1));
                    wait_fill_reg <= wait_fill_reg - (TW+1)'(1);
                end
                OP_GR_TAKE:
                begin
                    owner_valid_reg        <= 1'b1;
                    owner_id_reg           <= grant_tid_reg;
                    owner_depth_reg        <= saved_rdata;
                    ready_head_reg         <= wrap_add(ready_head_reg, (TW+1)'(1));
                    ready_fill_reg         <= ready_fill_reg - (TW+1)'(1);
                    blocked_reg[grant_idx] <= 1'b0;
                end
                OP_TO_NEXT, OP_SH_WRITE: idx_reg <= idx_plus1[TW-1:0];
                OP_TO_FOUND: blocked_reg[tid_idx] <= 1'b0;
                OP_TO_DROP:  wait_fill_reg <= wait_fill_reg - (TW+1)'(1);
                OP_TO_TAKE:
                begin
                    owner_valid_reg <= 1'b1;
                    owner_id_reg    <= tid_reg;
                    owner_depth_reg <= saved_rdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            req_reg   <= req_type;
            tid_reg   <= thread_id;
            timed_reg <= 1'b0;
            woke_reg  <= 1'b0;
            woken_reg <= '0;
            moved_reg <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.op == OP_NT_MOVE)
        begin
            moved_reg <= moved_reg + (TW+1)'(1);
        end
        if (cmd.op == OP_GR_READ_SAVED)
        begin
            grant_tid_reg <= fifo_rdata;
        end
        if (cmd.op == OP_TO_FOUND)
        begin
            timed_reg <= 1'b1;
        end
        if (cmd.op == OP_GR_TAKE)
        begin
            woke_reg  <= 1'b1;
            woken_reg <= grant_tid_reg;
        end
        if (cmd.op == OP_TO_TAKE)
        begin
            woke_reg  <= 1'b1;
            woken_reg <= tid_reg;
        end
    end

    always_comb
    begin
        st.req              = req_reg;
        st.tid_bad          = (tid_ext >= (TW+TID_W)'(THREAD_COUNT));
        st.blocked          = blocked_reg[tid_idx];
        st.holds            = owner_valid_reg && (owner_id_reg == tid_reg);
        st.owner_valid      = owner_valid_reg;
        st.depth_at_max     = (owner_depth_reg >= DW'(DEPTH_MAX));
        st.depth_gt1        = (owner_depth_reg > DW'(1));
        st.wait_empty       = (wait_fill_reg == '0);
        st.wait_gt1         = (wait_fill_reg > (TW+1)'(1));
        st.ready_empty      = (ready_fill_reg == '0);
        st.match            = (wait_rdata == tid_reg);
        st.idx_next_lt_fill = (idx_plus1 < wait_fill_reg);
    end

    assign depth_ext    = {{NEST_W{1'b0}}, owner_depth_reg};
    assign moved_ext    = {{MOVED_W{1'b0}}, moved_reg};
    assign status       = status_reg;
    assign timed_out    = timed_reg;
    assign woken_valid  = woke_reg;
    assign woken_thread = woken_reg;
    assign holder_valid = owner_valid_reg;
    assign holder_now   = owner_valid_reg ? owner_id_reg : '0;
    assign nest_count   = owner_valid_reg ? depth_ext[NEST_W-1:0] : '0;
    assign moved_count  = moved_ext[MOVED_W-1:0];

endmodule

`default_nettype wire

### sv/reentrant_monitor_lock_unit_top.sv
// A simple request is captured, decoded and presented; release, wait and notify also
// check the ready queue and, if the lock is free, hand it to the head of that queue.
// Notify moves each woken waiter to the ready queue; a timeout searches the wait list,
// shifts later entries down, drops the last and queues the thread or gives it the lock.
// Requests are taken one at a time, each only after the result of the last is taken.
// Reset: asynchronous, clears holder, queue pointers and blocked flags; no sweep.
// ----------------------------------------------------------------------------
// Reentrant monitor lock unit top level
// Controller and datapath for a reentrant lock with ready and wait queues.
// ----------------------------------------------------------------------------
`default_nettype none

module reentrant_monitor_lock_unit_top #(
    parameter int THREAD_COUNT = rmlu_pkg::THREAD_COUNT_DEF,
    parameter int DEPTH_MAX    = rmlu_pkg::DEPTH_MAX_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rmlu_pkg::REQ_W-1:0]    req_type,
    input  wire logic [rmlu_pkg::TID_W-1:0]    thread_id,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [rmlu_pkg::STATUS_W-1:0] status,
    output logic                               timed_out,
    output logic                               woken_valid,
    output logic      [rmlu_pkg::TID_W-1:0]    woken_thread,
    output logic                               holder_valid,
    output logic      [rmlu_pkg::TID_W-1:0]    holder_now,
    output logic      [rmlu_pkg::NEST_W-1:0]   nest_count,
    output logic      [rmlu_pkg::MOVED_W-1:0]  moved_count
);

    import rmlu_pkg::*;

    cmd_t  cmd;
    stat_t st;

    rmlu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    rmlu_dp #(
        .THREAD_COUNT (THREAD_COUNT),
        .DEPTH_MAX    (DEPTH_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .req_type     (req_type),
        .thread_id    (thread_id),
        .status       (status),
        .timed_out    (timed_out),
        .woken_valid  (woken_valid),
        .woken_thread (woken_thread),
        .holder_valid (holder_valid),
        .holder_now   (holder_now),
        .nest_count   (nest_count),
        .moved_count  (moved_count)
    );

endmodule

`default_nettype wire
